// File: src/sysrs_pkg.sv
// Shared constants, codes and state type of the systematic resampler.
package sysrs_pkg;

   // Capacity and derived widths
   localparam int MAX_PARTICLES = 1024;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

   // Field widths
   localparam int WEIGHT_W  = 16;
   localparam int OFFSET_W  = 16;
   localparam int FRAC_W    = 16;
   localparam int RATIO_W   = 17;
   localparam int OUTCOME_W = 2;

   // Accumulator and product widths
   localparam int SUM_W  = WEIGHT_W + IDX_W;
   localparam int SQ_W   = 2 * WEIGHT_W;
   localparam int QSUM_W = SQ_W + IDX_W;
   localparam int QLO_W  = QSUM_W / 2;
   localparam int QHI_W  = QSUM_W - QLO_W;
   localparam int RN_W   = RATIO_W + CNT_W;
   localparam int PLO_W  = RN_W + QLO_W;
   localparam int PHI_W  = RN_W + QHI_W;
   localparam int RHS_W  = RN_W + QSUM_W;
   localparam int SS_W   = 2 * SUM_W;
   localparam int LHS_W  = SS_W + FRAC_W;
   localparam int U_W    = FRAC_W + IDX_W;
   localparam int US_W   = U_W + SUM_W;
   localparam int CN_W   = SUM_W + CNT_W;
   localparam int CNS_W  = CN_W + FRAC_W;

   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(32768);

   // Commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // Result kinds
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_DRAW   = 1'b1;

   // Outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_UNIFORM   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_KEPT      = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_RESAMPLED = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_REFUSED   = 2'd3;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DEC_SQ,
      ST_DEC_LO,
      ST_DEC_HI,
      ST_DEC_CMP,
      ST_DRAW_U,
      ST_WALK_MUL,
      ST_WALK_CMP,
      ST_DRAW_FIN,
      ST_EMIT
   } state_type;

endpackage

// File: src/sysrs_if.sv
// Request and response channel interfaces of the systematic resampler.
interface sysrs_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [sysrs_pkg::WEIGHT_W-1:0]   weight;
   logic                             final_weight;
   logic [sysrs_pkg::OFFSET_W-1:0]   random_offset;

   modport source (output valid, command, weight, final_weight, random_offset,
                   input ready);
   modport sink   (input valid, command, weight, final_weight, random_offset,
                   output ready);
endinterface

interface sysrs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [sysrs_pkg::OUTCOME_W-1:0]  outcome;
   logic [sysrs_pkg::IDX_W-1:0]      source_index;
   logic                             draw_done;

   modport source (output valid, kind, outcome, source_index, draw_done,
                   input ready);
   modport sink   (input valid, kind, outcome, source_index, draw_done,
                   output ready);
endinterface

// File: src/systematic_resampler.sv
// Systematic resampler: weight store, round decision and cumulative walk.
//
// Usage: weights arrive on the req_bus channel one beat at a time with
// command load; the beat with final_weight set closes the round and carries
// the random offset. That beat yields one report beat on rsp_bus (uniform
// reset, kept or resampled). Each later draw beat yields one index beat; the
// last draw of a round has draw_done set and clears the round. Draws with no
// round ready, or past the last one, come back refused. Loads past capacity
// are dropped, but a final mark on them still closes the round.
// Timing: one item at a time. A non-final load passes the load state only; a
// final load then runs the square, low and high product states (split
// product for the decision test) and the compare state to its report.
// A kept or uniform draw runs the finish state, a refused one none; each walk
// step of a resampled draw is one weight memory read and one multiply/compare.
// Reset clears the round, the sums and the ratio register (32768); the weight
// memory keeps its contents and needs no clearing. A result waits in the
// output register while rsp_bus.ready is low; the next item is still accepted
// but its own result waits until that register frees.
module systematic_resampler (
   input  logic                                clock,
   input  logic                                reset,
   sysrs_req_if.sink                           req_bus,
   sysrs_rsp_if.source                         rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [sysrs_pkg::RATIO_W-1:0]       csr_write_data
);

   // Weight memory
   logic [sysrs_pkg::WEIGHT_W-1:0] weight_mem [sysrs_pkg::MAX_PARTICLES];
   logic [sysrs_pkg::WEIGHT_W-1:0] rd_data_ff;
   logic                           mem_we;
   logic [sysrs_pkg::IDX_W-1:0]    wr_addr;
   logic [sysrs_pkg::IDX_W-1:0]    rd_addr;

   // Sequencer
   sysrs_pkg::state_type state_ff, state_in;

   // Round state
   logic [sysrs_pkg::RATIO_W-1:0]   ratio_ff;
   logic [sysrs_pkg::CNT_W-1:0]     count_ff;
   logic [sysrs_pkg::SUM_W-1:0]     total_ff;
   logic [sysrs_pkg::QSUM_W-1:0]    sq_total_ff;
   logic [sysrs_pkg::SUM_W-1:0]     cum_ff;
   logic [sysrs_pkg::IDX_W-1:0]     pos_ff;
   logic [sysrs_pkg::CNT_W-1:0]     dc_ff;
   logic [sysrs_pkg::OFFSET_W-1:0]  offset_ff;
   logic                            round_ready_ff;
   logic [sysrs_pkg::OUTCOME_W-1:0] round_kind_ff;

   // Captured load beat and intermediate products
   logic [sysrs_pkg::WEIGHT_W-1:0]  w_ff;
   logic [sysrs_pkg::SQ_W-1:0]      wsq_ff;
   logic                            final_ff;
   logic [sysrs_pkg::OFFSET_W-1:0]  new_offset_ff;
   logic [sysrs_pkg::SS_W-1:0]      lhs_ff;
   logic [sysrs_pkg::RN_W-1:0]      rn_ff;
   logic [sysrs_pkg::PLO_W-1:0]     prod_lo_ff;
   logic [sysrs_pkg::PHI_W-1:0]     prod_hi_ff;
   logic [sysrs_pkg::US_W-1:0]      us_ff;
   logic [sysrs_pkg::CN_W-1:0]      cn_ff;

   // Pending result and output register
   logic                            pend_kind_ff;
   logic [sysrs_pkg::OUTCOME_W-1:0] pend_outcome_ff;
   logic [sysrs_pkg::IDX_W-1:0]     pend_index_ff;
   logic                            pend_done_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_kind_ff;
   logic [sysrs_pkg::OUTCOME_W-1:0] rsp_outcome_ff;
   logic [sysrs_pkg::IDX_W-1:0]     rsp_index_ff;
   logic                            rsp_done_ff;

   // Decoded conditions
   logic                            accept;
   logic                            rsp_free;
   logic                            draw_refused;
   logic                            resampled;
   logic [sysrs_pkg::CNT_W-1:0]     base_count;
   logic [sysrs_pkg::SUM_W-1:0]     base_total;
   logic [sysrs_pkg::QSUM_W-1:0]    base_sq_total;
   logic                            has_space;
   logic [sysrs_pkg::CNT_W-1:0]     pos_next;
   logic                            walk_stop;
   logic [sysrs_pkg::U_W-1:0]       u_value;
   logic [sysrs_pkg::RHS_W-1:0]     rhs_value;
   logic                            less_than;
   logic [sysrs_pkg::OUTCOME_W-1:0] decision;
   logic [sysrs_pkg::CNT_W-1:0]     dc_next;
   logic                            last_draw;

   // Decode handshake and round conditions
   assign accept       = req_bus.valid && req_bus.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_bus.ready;
   assign draw_refused = !round_ready_ff || (dc_ff >= count_ff);
   assign resampled    = (round_kind_ff == sysrs_pkg::OUT_RESAMPLED);

   // Drop the old round when a load follows a finished decision
   assign base_count    = round_ready_ff ? '0 : count_ff;
   assign base_total    = round_ready_ff ? '0 : total_ff;
   assign base_sq_total = round_ready_ff ? '0 : sq_total_ff;
   assign has_space     = base_count < sysrs_pkg::CNT_W'(sysrs_pkg::MAX_PARTICLES);

   // Walk step test: stop once cum*N*2^16 reaches u*S or at the last entry
   assign pos_next  = sysrs_pkg::CNT_W'(pos_ff) + sysrs_pkg::CNT_W'(1);
   assign walk_stop = ({cn_ff, {sysrs_pkg::FRAC_W{1'b0}}} >= sysrs_pkg::CNS_W'(us_ff))
                      || (pos_next >= count_ff);

   // Draw point in raw scale
   assign u_value = sysrs_pkg::U_W'({dc_ff[sysrs_pkg::IDX_W-1:0],
                                     {sysrs_pkg::FRAC_W{1'b0}}})
                    + sysrs_pkg::U_W'(offset_ff);

   // Decision test: S*S*2^16 < ratio*N*Q
   assign rhs_value = sysrs_pkg::RHS_W'({prod_hi_ff, {sysrs_pkg::QLO_W{1'b0}}})
                      + sysrs_pkg::RHS_W'(prod_lo_ff);
   assign less_than = sysrs_pkg::RHS_W'({lhs_ff, {sysrs_pkg::FRAC_W{1'b0}}}) < rhs_value;
   assign decision  = (total_ff == '0) ? sysrs_pkg::OUT_UNIFORM :
                      (less_than ? sysrs_pkg::OUT_RESAMPLED : sysrs_pkg::OUT_KEPT);

   assign dc_next   = dc_ff + sysrs_pkg::CNT_W'(1);
   assign last_draw = (dc_next == count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sysrs_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_bus.command == sysrs_pkg::CMD_LOAD) begin
                  state_in = sysrs_pkg::ST_LOAD;
               end else if (draw_refused) begin
                  state_in = sysrs_pkg::ST_EMIT;
               end else if (resampled) begin
                  state_in = sysrs_pkg::ST_DRAW_U;
               end else begin
                  state_in = sysrs_pkg::ST_DRAW_FIN;
               end
            end
         end
         sysrs_pkg::ST_LOAD:     state_in = final_ff ? sysrs_pkg::ST_DEC_SQ : sysrs_pkg::ST_IDLE;
         sysrs_pkg::ST_DEC_SQ:   state_in = sysrs_pkg::ST_DEC_LO;
         sysrs_pkg::ST_DEC_LO:   state_in = sysrs_pkg::ST_DEC_HI;
         sysrs_pkg::ST_DEC_HI:   state_in = sysrs_pkg::ST_DEC_CMP;
         sysrs_pkg::ST_DEC_CMP:  state_in = sysrs_pkg::ST_EMIT;
         sysrs_pkg::ST_DRAW_U:   state_in = sysrs_pkg::ST_WALK_MUL;
         sysrs_pkg::ST_WALK_MUL: state_in = sysrs_pkg::ST_WALK_CMP;
         sysrs_pkg::ST_WALK_CMP: begin
            state_in = walk_stop ? sysrs_pkg::ST_DRAW_FIN : sysrs_pkg::ST_WALK_MUL;
         end
         sysrs_pkg::ST_DRAW_FIN: state_in = sysrs_pkg::ST_EMIT;
         sysrs_pkg::ST_EMIT:     state_in = rsp_free ? sysrs_pkg::ST_IDLE : sysrs_pkg::ST_EMIT;
         default:                state_in = sysrs_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: ready, memory write and read addresses
   always_comb begin
      req_bus.ready = 1'b0;
      mem_we        = 1'b0;
      wr_addr       = base_count[sysrs_pkg::IDX_W-1:0];
      rd_addr       = pos_next[sysrs_pkg::IDX_W-1:0];
      unique case (state_ff)
         sysrs_pkg::ST_IDLE:   req_bus.ready = 1'b1;
         sysrs_pkg::ST_LOAD:   mem_we        = has_space;
         sysrs_pkg::ST_DEC_SQ: rd_addr       = '0;
         default: begin
         end
      endcase
   end

   // Weight memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[wr_addr] <= w_ff;
      end
      rd_data_ff <= weight_mem[rd_addr];
   end

   // Output channel valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (state_ff == sysrs_pkg::ST_EMIT && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sysrs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ratio_ff     <= sysrs_pkg::RATIO_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            ratio_ff <= csr_write_data;
         end
      end
   end

   // Round state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         total_ff       <= '0;
         sq_total_ff    <= '0;
         cum_ff         <= '0;
         pos_ff         <= '0;
         dc_ff          <= '0;
         offset_ff      <= '0;
         round_ready_ff <= 1'b0;
         round_kind_ff  <= sysrs_pkg::OUT_UNIFORM;
      end else begin
         unique case (state_ff)
            sysrs_pkg::ST_LOAD: begin
               round_ready_ff <= 1'b0;
               if (has_space) begin
                  count_ff    <= base_count + sysrs_pkg::CNT_W'(1);
                  total_ff    <= base_total + sysrs_pkg::SUM_W'(w_ff);
                  sq_total_ff <= base_sq_total + sysrs_pkg::QSUM_W'(wsq_ff);
               end else begin
                  count_ff    <= base_count;
                  total_ff    <= base_total;
                  sq_total_ff <= base_sq_total;
               end
               if (final_ff) begin
                  offset_ff <= new_offset_ff;
               end
            end
            sysrs_pkg::ST_DEC_LO: begin
               cum_ff <= (count_ff != '0) ? sysrs_pkg::SUM_W'(rd_data_ff) : '0;
            end
            sysrs_pkg::ST_DEC_CMP: begin
               round_ready_ff <= 1'b1;
               round_kind_ff  <= decision;
               dc_ff          <= '0;
               pos_ff         <= '0;
            end
            sysrs_pkg::ST_WALK_CMP: begin
               if (!walk_stop) begin
                  pos_ff <= pos_next[sysrs_pkg::IDX_W-1:0];
                  cum_ff <= cum_ff + sysrs_pkg::SUM_W'(rd_data_ff);
               end
            end
            sysrs_pkg::ST_DRAW_FIN: begin
               if (last_draw) begin
                  count_ff       <= '0;
                  total_ff       <= '0;
                  sq_total_ff    <= '0;
                  cum_ff         <= '0;
                  pos_ff         <= '0;
                  dc_ff          <= '0;
                  round_ready_ff <= 1'b0;
               end else begin
                  dc_ff <= dc_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers: captured beat, products, pending result
   always_ff @(posedge clock) begin
      if (state_ff == sysrs_pkg::ST_IDLE && accept) begin
         w_ff          <= req_bus.weight;
         wsq_ff        <= req_bus.weight * req_bus.weight;
         final_ff      <= req_bus.final_weight;
         new_offset_ff <= req_bus.random_offset;
         if (req_bus.command == sysrs_pkg::CMD_DRAW) begin
            pend_kind_ff    <= sysrs_pkg::KIND_DRAW;
            pend_outcome_ff <= sysrs_pkg::OUT_REFUSED;
            pend_index_ff   <= '0;
            pend_done_ff    <= 1'b0;
         end
      end
      unique case (state_ff)
         sysrs_pkg::ST_DEC_SQ: begin
            lhs_ff <= sysrs_pkg::SS_W'(total_ff) * sysrs_pkg::SS_W'(total_ff);
            rn_ff  <= sysrs_pkg::RN_W'(ratio_ff) * sysrs_pkg::RN_W'(count_ff);
         end
         sysrs_pkg::ST_DEC_LO: begin
            prod_lo_ff <= sysrs_pkg::PLO_W'(rn_ff)
                          * sysrs_pkg::PLO_W'(sq_total_ff[sysrs_pkg::QLO_W-1:0]);
         end
         sysrs_pkg::ST_DEC_HI: begin
            prod_hi_ff <= sysrs_pkg::PHI_W'(rn_ff)
                          * sysrs_pkg::PHI_W'(sq_total_ff[sysrs_pkg::QSUM_W-1:sysrs_pkg::QLO_W]);
         end
         sysrs_pkg::ST_DEC_CMP: begin
            pend_kind_ff    <= sysrs_pkg::KIND_REPORT;
            pend_outcome_ff <= decision;
            pend_index_ff   <= '0;
            pend_done_ff    <= 1'b0;
         end
         sysrs_pkg::ST_DRAW_U: begin
            us_ff <= sysrs_pkg::US_W'(u_value) * sysrs_pkg::US_W'(total_ff);
         end
         sysrs_pkg::ST_WALK_MUL: begin
            cn_ff <= sysrs_pkg::CN_W'(cum_ff) * sysrs_pkg::CN_W'(count_ff);
         end
         sysrs_pkg::ST_DRAW_FIN: begin
            pend_kind_ff    <= sysrs_pkg::KIND_DRAW;
            pend_outcome_ff <= round_kind_ff;
            pend_index_ff   <= resampled ? pos_ff : dc_ff[sysrs_pkg::IDX_W-1:0];
            pend_done_ff    <= last_draw;
         end
         default: begin
         end
      endcase
      // Move the pending result into the output register
      if (state_ff == sysrs_pkg::ST_EMIT && rsp_free) begin
         rsp_kind_ff    <= pend_kind_ff;
         rsp_outcome_ff <= pend_outcome_ff;
         rsp_index_ff   <= pend_index_ff;
         rsp_done_ff    <= pend_done_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = rsp_kind_ff;
   assign rsp_bus.outcome      = rsp_outcome_ff;
   assign rsp_bus.source_index = rsp_index_ff;
   assign rsp_bus.draw_done    = rsp_done_ff;

   // Checks
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sysrs_pkg::CNT_W'(sysrs_pkg::MAX_PARTICLES))
      else $error("loaded count beyond capacity");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sysrs_pkg::ST_WALK_MUL || state_ff == sysrs_pkg::ST_WALK_CMP)
      |-> (sysrs_pkg::CNT_W'(pos_ff) < count_ff))
      else $error("walk position outside loaded weights");

   a_draw_counter: assert property (@(posedge clock) disable iff (reset)
      (round_ready_ff && count_ff != '0) |-> (dc_ff < count_ff))
      else $error("draw counter ran past the round");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sysrs_pkg::ST_EMIT && rsp_free) |=> rsp_valid_ff)
      else $error("pending result not presented");

endmodule
